// ----- src/entab_tab_stop_list_macros.svh -----
// assertion macros shared by the entab modules
`ifndef ENTAB_TAB_STOP_LIST_MACROS_SVH
`define ENTAB_TAB_STOP_LIST_MACROS_SVH

// condition must hold at every clock edge out of reset
`define ENTAB_ASSERT(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("entab assertion failed");

// consequent must hold in the cycle after the antecedent
`define ENTAB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("entab assertion failed");

`endif

// ----- src/entab_pkg.sv -----
// shared types, constants and helpers of the entab block
`timescale 1ns / 1ps

package entab_pkg;

	// character codes
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	// field and register widths
	localparam int CHAR_W   = 8;
	localparam int WIDTH_W  = 6;
	localparam int COUNT_W  = 3;
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;

	// frame geometry
	localparam int MAX_WIDTH       = 63;
	localparam int NUM_STOP_REGS   = 6;
	localparam int MAX_STOPS_DEF   = 6;
	localparam logic [WIDTH_W-1:0] RESET_WIDTH = 6'd4;

	// command queue depth
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;

	// request types
	typedef enum logic {
		REQ_TEXT = 1'b0,
		REQ_EOT  = 1'b1
	} req_type_t;

	// register indexes
	typedef enum logic [2:0] {
		REG_DEFAULT_WIDTH = 3'd0,
		REG_STOP_COUNT    = 3'd1,
		REG_STOP_ONE      = 3'd2,
		REG_STOP_TWO      = 3'd3,
		REG_STOP_THREE    = 3'd4,
		REG_STOP_FOUR     = 3'd5,
		REG_STOP_FIVE     = 3'd6,
		REG_STOP_SIX      = 3'd7
	} reg_idx_t;

	// configuration bus request
	typedef struct packed {
		logic              psel;
		logic              penable;
		logic              pwrite;
		logic [ADDR_W-1:0] paddr;
		logic [DATA_W-1:0] pwdata;
	} apb_req_t;

	// configuration register contents
	typedef struct packed {
		logic [WIDTH_W-1:0]                    default_width;
		logic [COUNT_W-1:0]                    stop_count;
		logic [NUM_STOP_REGS-1:0][WIDTH_W-1:0] stop_widths;
	} cfg_t;

	// one command for the back end: a run of spaces, then maybe a byte
	typedef struct packed {
		logic [WIDTH_W-1:0] spaces;
		logic               has_char;
		logic [CHAR_W-1:0]  char_code;
	} cmd_t;

	// a width of zero acts as one, widths cap at the maximum
	function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_W-1:0] w);
		logic [WIDTH_W-1:0] r;
		r = w;
		if (w == '0)
			r = WIDTH_W'(1);
		else if (w > WIDTH_W'(MAX_WIDTH))
			r = WIDTH_W'(MAX_WIDTH);
		return r;
	endfunction

endpackage

// ----- src/entab_regs.sv -----
// configuration register file with apb-style write and read
`timescale 1ns / 1ps

module entab_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  entab_pkg::apb_req_t             apb,
	output logic [entab_pkg::DATA_W-1:0]    prdata,
	output entab_pkg::cfg_t                 cfg
);

	entab_pkg::cfg_t      cfg_q;
	entab_pkg::reg_idx_t  idx;
	logic                 wr_en;

	assign idx   = entab_pkg::reg_idx_t'(apb.paddr[entab_pkg::ADDR_W-1:2]);
	assign wr_en = apb.psel && apb.penable && apb.pwrite;
	assign cfg   = cfg_q;

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.default_width <= entab_pkg::RESET_WIDTH;
			cfg_q.stop_count    <= '0;
			for (int i = 0; i < entab_pkg::NUM_STOP_REGS; i++)
				cfg_q.stop_widths[i] <= entab_pkg::RESET_WIDTH;
		end else if (wr_en) begin
			case (idx)
				entab_pkg::REG_DEFAULT_WIDTH:
					cfg_q.default_width <= apb.pwdata[entab_pkg::WIDTH_W-1:0];
				entab_pkg::REG_STOP_COUNT:
					cfg_q.stop_count <= apb.pwdata[entab_pkg::COUNT_W-1:0];
				entab_pkg::REG_STOP_ONE:
					cfg_q.stop_widths[0] <= apb.pwdata[entab_pkg::WIDTH_W-1:0];
				entab_pkg::REG_STOP_TWO:
					cfg_q.stop_widths[1] <= apb.pwdata[entab_pkg::WIDTH_W-1:0];
				entab_pkg::REG_STOP_THREE:
					cfg_q.stop_widths[2] <= apb.pwdata[entab_pkg::WIDTH_W-1:0];
				entab_pkg::REG_STOP_FOUR:
					cfg_q.stop_widths[3] <= apb.pwdata[entab_pkg::WIDTH_W-1:0];
				entab_pkg::REG_STOP_FIVE:
					cfg_q.stop_widths[4] <= apb.pwdata[entab_pkg::WIDTH_W-1:0];
				entab_pkg::REG_STOP_SIX:
					cfg_q.stop_widths[5] <= apb.pwdata[entab_pkg::WIDTH_W-1:0];
				default: ;
			endcase
		end
	end

	// register read
	always_comb begin
		prdata = '0;
		case (idx)
			entab_pkg::REG_DEFAULT_WIDTH:
				prdata = entab_pkg::DATA_W'(cfg_q.default_width);
			entab_pkg::REG_STOP_COUNT:
				prdata = entab_pkg::DATA_W'(cfg_q.stop_count);
			entab_pkg::REG_STOP_ONE:   prdata = entab_pkg::DATA_W'(cfg_q.stop_widths[0]);
			entab_pkg::REG_STOP_TWO:   prdata = entab_pkg::DATA_W'(cfg_q.stop_widths[1]);
			entab_pkg::REG_STOP_THREE: prdata = entab_pkg::DATA_W'(cfg_q.stop_widths[2]);
			entab_pkg::REG_STOP_FOUR:  prdata = entab_pkg::DATA_W'(cfg_q.stop_widths[3]);
			entab_pkg::REG_STOP_FIVE:  prdata = entab_pkg::DATA_W'(cfg_q.stop_widths[4]);
			entab_pkg::REG_STOP_SIX:   prdata = entab_pkg::DATA_W'(cfg_q.stop_widths[5]);
			default: prdata = '0;
		endcase
	end

endmodule

// ----- src/entab_front.sv -----
// front end: tracks frame position and turns requests into commands
`timescale 1ns / 1ps
`include "entab_tab_stop_list_macros.svh"

module entab_front #(
	parameter int MAX_STOPS = entab_pkg::MAX_STOPS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  entab_pkg::cfg_t                cfg,
	input  logic                           accept,
	input  logic                           req_type,
	input  logic [entab_pkg::CHAR_W-1:0]   char_code,
	output logic                           cmd_wr,
	output entab_pkg::cmd_t                cmd
);

	localparam int SIW = $clog2(MAX_STOPS + 1);

	logic [entab_pkg::WIDTH_W-1:0] frame_column_q, pending_q;
	logic [SIW-1:0]                stop_index_q;

	logic [entab_pkg::WIDTH_W-1:0] col_n, pend_n;
	logic [SIW-1:0]                idx_n, idx_inc;
	logic [entab_pkg::WIDTH_W-1:0] col_inc, sel_width, width;
	logic [entab_pkg::COUNT_W-1:0] used;
	logic                          frame_full;

	// number of listed stops in effect
	assign used = (cfg.stop_count > entab_pkg::COUNT_W'(MAX_STOPS)) ?
		entab_pkg::COUNT_W'(MAX_STOPS) : cfg.stop_count;

	// width of the current frame
	always_comb begin
		sel_width = cfg.default_width;
		if (entab_pkg::COUNT_W'(stop_index_q) < used) begin
			for (int i = 0; i < MAX_STOPS; i++) begin
				if (stop_index_q == SIW'(i))
					sel_width = cfg.stop_widths[i];
			end
		end
	end

	assign width      = entab_pkg::clamp_width(sel_width);
	assign col_inc    = entab_pkg::WIDTH_W'(frame_column_q + entab_pkg::WIDTH_W'(1));
	assign frame_full = col_inc >= width;
	assign idx_inc    = (stop_index_q < SIW'(MAX_STOPS)) ?
		SIW'(stop_index_q + SIW'(1)) : stop_index_q;

	// classify the request
	always_comb begin
		col_n          = frame_column_q;
		pend_n         = pending_q;
		idx_n          = stop_index_q;
		cmd_wr         = 1'b0;
		cmd.spaces     = pending_q;
		cmd.has_char   = 1'b0;
		cmd.char_code  = char_code;
		if (req_type == entab_pkg::REQ_EOT) begin
			cmd_wr = accept && (pending_q != '0);
			col_n  = '0;
			pend_n = '0;
			idx_n  = '0;
		end else if (char_code == entab_pkg::CH_NEWLINE) begin
			cmd_wr       = accept;
			cmd.has_char = 1'b1;
			col_n        = '0;
			pend_n       = '0;
			idx_n        = '0;
		end else if (char_code == entab_pkg::CH_SPACE) begin
			// held spaces that reach the frame end become one tab
			if (frame_full) begin
				cmd_wr        = accept;
				cmd.spaces    = '0;
				cmd.has_char  = 1'b1;
				cmd.char_code = entab_pkg::CH_TAB;
				col_n         = '0;
				pend_n        = '0;
				idx_n         = idx_inc;
			end else begin
				col_n  = col_inc;
				pend_n = entab_pkg::WIDTH_W'(pending_q + entab_pkg::WIDTH_W'(1));
			end
		end else begin
			cmd_wr       = accept;
			cmd.has_char = 1'b1;
			pend_n       = '0;
			if (frame_full) begin
				col_n = '0;
				idx_n = idx_inc;
			end else begin
				col_n = col_inc;
			end
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_column_q <= '0;
			pending_q      <= '0;
			stop_index_q   <= '0;
		end else if (accept) begin
			frame_column_q <= col_n;
			pending_q      <= pend_n;
			stop_index_q   <= idx_n;
		end
	end

	`ENTAB_ASSERT(a_pend_le_col, pending_q <= frame_column_q)
	`ENTAB_ASSERT(a_idx_range, stop_index_q <= SIW'(MAX_STOPS))
	`ENTAB_ASSERT(a_cmd_nonempty, !cmd_wr || cmd.has_char || (cmd.spaces != '0))

endmodule

// ----- src/entab_fifo.sv -----
// short command queue between front and back ends
`timescale 1ns / 1ps

module entab_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  entab_pkg::cmd_t  wdata,
	input  logic             rd,
	output entab_pkg::cmd_t  rdata,
	output logic             full,
	output logic             empty
);

	localparam int PW = entab_pkg::FIFO_PTR_W;

	entab_pkg::cmd_t   mem_q [entab_pkg::FIFO_DEPTH];
	entab_pkg::cmd_t   rdata_q;
	logic [PW-1:0]     wptr_q, rptr_q, rd_addr;
	logic [PW:0]       count_q;

	assign full  = count_q == (PW+1)'(entab_pkg::FIFO_DEPTH);
	assign empty = count_q == '0;
	assign rdata = rdata_q;

	// slot that holds the head after this edge
	assign rd_addr = rd ? PW'(rptr_q + PW'(1)) : rptr_q;

	// storage
	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wptr_q] <= wdata;
	end

	// head register, taken straight from the write side when the head slot is being written
	always_ff @(posedge clk) begin
		if (wr && (wptr_q == rd_addr))
			rdata_q <= wdata;
		else
			rdata_q <= mem_q[rd_addr];
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr)
				wptr_q <= PW'(wptr_q + PW'(1));
			if (rd)
				rptr_q <= PW'(rptr_q + PW'(1));
			if (wr && !rd)
				count_q <= (PW+1)'(count_q + (PW+1)'(1));
			else if (rd && !wr)
				count_q <= (PW+1)'(count_q - (PW+1)'(1));
		end
	end

endmodule

// ----- src/entab_back.sv -----
// back end: plays out each command as its spaces and, if it has one, a trailing byte
`timescale 1ns / 1ps
`include "entab_tab_stop_list_macros.svh"

module entab_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  entab_pkg::cmd_t                head,
	input  logic                           head_empty,
	input  logic                           pop,
	output logic                           head_rd,
	output logic [entab_pkg::CHAR_W-1:0]   out_char,
	output logic                           last
);

	logic [entab_pkg::WIDTH_W-1:0] cnt_q, cnt_inc;
	logic                          in_spaces, take;

	assign cnt_inc   = entab_pkg::WIDTH_W'(cnt_q + entab_pkg::WIDTH_W'(1));
	assign in_spaces = cnt_q != head.spaces;
	assign out_char  = in_spaces ? entab_pkg::CH_SPACE : head.char_code;
	assign last      = in_spaces ? ((cnt_inc == head.spaces) && !head.has_char) : 1'b1;
	assign take      = pop && !head_empty;
	assign head_rd   = take && last;

	// spaces already sent for the head command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (take)
			cnt_q <= last ? '0 : cnt_inc;
	end

	`ENTAB_ASSERT(a_cnt_bound, head_empty || (cnt_q <= head.spaces))
	`ENTAB_ASSERT(a_cnt_idle, !head_empty || (cnt_q == '0))
	`ENTAB_ASSERT_NEXT(a_cnt_clear, head_rd, cnt_q == '0)

endmodule

// ----- src/entab_tab_stop_list.sv -----
// top level of the entab block with a list of tab stops
//
//   channel   direction  handshake              payload
//   input     in         push / full            req_type, char_code
//   result    out        pop / empty            out_char, last
//   config    in         psel/penable/pwrite    paddr, pwdata, prdata
//
// one request is taken per cycle while the command queue has room
// results leave at one per cycle while popped and not empty; a request fans out to up to 63 of them
// the back end space counter sets the result rate, the queue absorbs bursts
// full rises when the four-entry command queue is full
// arst_n clears frame state, queue and registers (widths 4, stop count 0)
`timescale 1ns / 1ps

module entab_tab_stop_list #(
	parameter int MAX_STOPS = entab_pkg::MAX_STOPS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [entab_pkg::ADDR_W-1:0]   paddr,
	input  logic [entab_pkg::DATA_W-1:0]   pwdata,
	output logic [entab_pkg::DATA_W-1:0]   prdata,
	output logic                           pready,
	input  logic                           push,
	output logic                           full,
	input  logic                           req_type,
	input  logic [entab_pkg::CHAR_W-1:0]   char_code,
	output logic                           empty,
	input  logic                           pop,
	output logic [entab_pkg::CHAR_W-1:0]   out_char,
	output logic                           last
);

	entab_pkg::apb_req_t apb;
	entab_pkg::cfg_t     cfg;
	entab_pkg::cmd_t     cmd, head;
	logic                accept, cmd_wr, head_rd;

	assign pready = 1'b1;
	assign accept = push && !full;

	// configuration bus
	always_comb begin
		apb.psel    = psel;
		apb.penable = penable;
		apb.pwrite  = pwrite;
		apb.paddr   = paddr;
		apb.pwdata  = pwdata;
	end

	entab_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.apb    (apb),
		.prdata (prdata),
		.cfg    (cfg)
	);

	entab_front #(
		.MAX_STOPS (MAX_STOPS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.accept    (accept),
		.req_type  (req_type),
		.char_code (char_code),
		.cmd_wr    (cmd_wr),
		.cmd       (cmd)
	);

	entab_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd_wr),
		.wdata  (cmd),
		.rd     (head_rd),
		.rdata  (head),
		.full   (full),
		.empty  (empty)
	);

	entab_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_empty (empty),
		.pop        (pop),
		.head_rd    (head_rd),
		.out_char   (out_char),
		.last       (last)
	);

endmodule
